// ----- sv/icdf_pkg.sv -----
// shared types and constants of the inverse cdf table sampler
package icdf_pkg;

    // default table depth and field widths
    localparam int TABLE_DEPTH = 32768;
    localparam int IDX_W       = 15;
    localparam int VAL_W       = 64;
    localparam int U_W         = 63;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // xorshift128+ seeds and shift amounts
    localparam logic [VAL_W-1:0] SEED_A = 64'h7073_6575_646F_7261;
    localparam logic [VAL_W-1:0] SEED_B = 64'h6E64_6F6D_7365_6564;
    localparam int SHL_A = 23;
    localparam int SHR_T = 18;
    localparam int SHR_B = 5;

    // request commands
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_DRAW = 1'b1
    } t_cmd;

    // register index, taken from paddr bit 2
    localparam logic REG_TOP_VALUE = 1'b0;

    // control tag that travels with a table access
    typedef struct packed {
        logic vld;
        logic wr;
    } t_tag;

endpackage

// ----- sv/inverse_cdf_table_sampler_unit.sv -----
// inverse cdf sampler: table load, xorshift128+ draw, binary search over a ram
// load request: no result and busy stays low, so the next request may follow at once
// draw request: S reads, floor or ceil of log2(top_value+1) by the path, at most 15,
//   each sent once the previous read data returns through the address reduction
// busy covers the S reads and o_done strobes in the cycle after;
//   reset reloads generator seeds and top_value, table undefined; receiver cannot stall
module inverse_cdf_table_sampler_unit #(
    parameter int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [icdf_pkg::APB_AW-1:0]       paddr,
    input  logic [icdf_pkg::APB_DW-1:0]       pwdata,
    output logic [icdf_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // request side
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic [icdf_pkg::IDX_W-1:0]        i_entry_index,
    input  logic [icdf_pkg::VAL_W-1:0]        i_entry_value,
    // result side
    output logic                              o_done,
    output logic [icdf_pkg::IDX_W-1:0]        o_sample_value
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int HW = icdf_pkg::IDX_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } t_state;

    t_state                         r_state;
    logic [icdf_pkg::IDX_W-1:0]     r_top;
    logic [icdf_pkg::U_W-1:0]       r_u;
    logic [icdf_pkg::IDX_W-1:0]     r_lo;
    logic [HW-1:0]                  r_hi;
    logic [icdf_pkg::IDX_W-1:0]     r_mid;
    logic                           r_rd_vld;
    logic                           r_done;
    logic [icdf_pkg::IDX_W-1:0]     r_sample;

    logic                           w_accept;
    logic                           w_load;
    logic                           w_draw;
    logic                           w_cfg_wr;
    logic [icdf_pkg::VAL_W-1:0]     w_sum;
    logic [icdf_pkg::VAL_W-1:0]     w_rdata;
    logic                           w_less;
    logic [icdf_pkg::IDX_W-1:0]     w_lo_nx;
    logic [HW-1:0]                  w_hi_nx;
    logic [HW-1:0]                  w_mid_sum;
    logic [icdf_pkg::IDX_W-1:0]     w_mid_nx;
    logic                           w_more;
    logic [HW-1:0]                  w_hi0;
    logic [icdf_pkg::IDX_W-1:0]     w_mid0;
    logic                           w_more0;
    icdf_pkg::t_tag                 w_req_tag;
    logic [icdf_pkg::IDX_W-1:0]     w_req_idx;
    icdf_pkg::t_tag                 w_mem_tag;
    logic [AW-1:0]                  w_mem_addr;
    logic [icdf_pkg::VAL_W-1:0]     w_mem_data;

    // request handshake
    assign busy     = (r_state == ST_SEARCH);
    assign w_accept = start & ~busy;
    assign w_load   = w_accept & (i_command == icdf_pkg::CMD_LOAD);
    assign w_draw   = w_accept & (i_command == icdf_pkg::CMD_DRAW);

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign prdata   = (paddr[2] == icdf_pkg::REG_TOP_VALUE) ?
                      icdf_pkg::APB_DW'(r_top) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else if (w_cfg_wr && paddr[2] == icdf_pkg::REG_TOP_VALUE) begin
            r_top <= pwdata[icdf_pkg::IDX_W-1:0];
        end
    end

    // random source
    icdf_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_draw),
        .o_sum   (w_sum)
    );

    // first bisection interval from top_value
    assign w_hi0   = HW'(r_top) + HW'(1);
    assign w_mid0  = w_hi0[HW-1:1];
    assign w_more0 = (r_top != '0);

    // bisection step on the returned entry
    assign w_less    = ({1'b0, r_u} < w_rdata);
    assign w_lo_nx   = w_less ? r_lo : r_mid;
    assign w_hi_nx   = w_less ? HW'(r_mid) : r_hi;
    assign w_more    = (HW'(w_lo_nx) + HW'(1)) < w_hi_nx;
    assign w_mid_sum = HW'(w_lo_nx) + w_hi_nx;
    assign w_mid_nx  = w_mid_sum[HW-1:1];

    // table access request: loads and first read from idle, later reads from search
    always_comb begin
        w_req_tag = '0;
        w_req_idx = '0;
        case (r_state)
            ST_IDLE: begin
                w_req_tag.vld = w_load | (w_draw & w_more0);
                w_req_tag.wr  = w_load;
                w_req_idx     = w_load ? i_entry_index : w_mid0;
            end
            ST_SEARCH: begin
                w_req_tag.vld = r_rd_vld & w_more;
                w_req_tag.wr  = 1'b0;
                w_req_idx     = w_mid_nx;
            end
            default: begin
                w_req_tag = '0;
                w_req_idx = '0;
            end
        endcase
    end

    // address reduction to the table depth
    icdf_amod #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_amod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_req_tag),
        .i_idx   (w_req_idx),
        .i_data  (i_entry_value),
        .o_tag   (w_mem_tag),
        .o_addr  (w_mem_addr),
        .o_data  (w_mem_data)
    );

    // cumulative distribution table
    icdf_ram #(
        .WIDTH (icdf_pkg::VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_mem_tag.vld & w_mem_tag.wr),
        .i_waddr (w_mem_addr),
        .i_wdata (w_mem_data),
        .i_re    (w_mem_tag.vld & ~w_mem_tag.wr),
        .i_raddr (w_mem_addr),
        .o_rdata (w_rdata)
    );

    // read data valid in the cycle after the read leaves the reduction stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_mem_tag.vld & ~w_mem_tag.wr;
        end
    end

    // search control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_draw) begin
                        if (w_more0) begin
                            r_state <= ST_SEARCH;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (r_rd_vld && !w_more) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // search interval and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_draw) begin
            r_u      <= w_sum[icdf_pkg::VAL_W-1:1];
            r_lo     <= '0;
            r_hi     <= w_hi0;
            r_mid    <= w_mid0;
            r_sample <= '0;
        end else if (r_state == ST_SEARCH && r_rd_vld) begin
            r_lo     <= w_lo_nx;
            r_hi     <= w_hi_nx;
            r_mid    <= w_mid_nx;
            r_sample <= w_lo_nx;
        end
    end

    assign o_done         = r_done;
    assign o_sample_value = r_sample;

`ifndef SYNTHESIS
    // a result never shows while a search is still running
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && busy))
        else $error("result strobe during search");

    // the bisection interval never collapses
    a_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (HW'(r_lo) < r_hi))
        else $error("search interval empty");

    // a search starts only from a request
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("search began without a request");

    // table data returns only while searching
    a_rd_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SEARCH))
        else $error("table read data outside a search");
`endif

endmodule

// ----- sv/icdf_ram.sv -----
// generic simple dual-port ram with registered read
module icdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- sv/icdf_rng.sv -----
// xorshift128+ generator with two state words
module icdf_rng (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    output logic [icdf_pkg::VAL_W-1:0] o_sum
);

    logic [icdf_pkg::VAL_W-1:0] r_a;
    logic [icdf_pkg::VAL_W-1:0] r_b;
    logic [icdf_pkg::VAL_W-1:0] w_t;
    logic [icdf_pkg::VAL_W-1:0] w_b_nx;

    // output is the sum of the words before the update
    assign o_sum = r_a + r_b;

    // next state of the second word
    assign w_t    = r_a ^ (r_a << icdf_pkg::SHL_A);
    assign w_b_nx = w_t ^ r_b ^ (w_t >> icdf_pkg::SHR_T) ^ (r_b >> icdf_pkg::SHR_B);

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= icdf_pkg::SEED_A;
            r_b <= icdf_pkg::SEED_B;
        end else if (i_step) begin
            r_a <= r_b;
            r_b <= w_b_nx;
        end
    end

`ifndef SYNTHESIS
    // first word takes the old second word on each step
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_step) |=> (r_a == $past(r_b)))
        else $error("rng word a did not take word b");
`endif

endmodule

// ----- sv/icdf_amod.sv -----
// reduces a table index modulo the table depth, tag and data ride along
module icdf_amod #(
    parameter int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  icdf_pkg::t_tag                   i_tag,
    input  logic [icdf_pkg::IDX_W-1:0]       i_idx,
    input  logic [icdf_pkg::VAL_W-1:0]       i_data,
    output icdf_pkg::t_tag                   o_tag,
    output logic [$clog2(TABLE_DEPTH)-1:0]   o_addr,
    output logic [icdf_pkg::VAL_W-1:0]       o_data
);

    localparam int  AW     = $clog2(TABLE_DEPTH);
    localparam bit  DIRECT = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0) ||
                             (TABLE_DEPTH >= (2 ** icdf_pkg::IDX_W));

    if (DIRECT) begin : g_direct
        // power-of-two or covering depth: plain mask
        assign o_tag  = i_tag;
        assign o_data = i_data;
        if (AW <= icdf_pkg::IDX_W) begin : g_cut
            assign o_addr = i_idx[AW-1:0];
        end else begin : g_ext
            assign o_addr = {{(AW - icdf_pkg::IDX_W){1'b0}}, i_idx};
        end
    end else begin : g_recip
        // quotient estimate by reciprocal, then remainder with one correction
        localparam longint unsigned RECIP = (64'd1 << 32) / TABLE_DEPTH;
        localparam logic [31:0]     RECIP_W = RECIP[31:0];
        localparam logic [15:0]     DEPTH_W = 16'(TABLE_DEPTH);

        logic [46:0]                   w_prod;
        logic [29:0]                   w_qd;
        logic [15:0]                   w_rem;
        logic [15:0]                   w_mod;
        icdf_pkg::t_tag                r_tag1;
        logic [icdf_pkg::IDX_W-1:0]    r_idx1;
        logic [icdf_pkg::IDX_W-1:0]    r_q1;
        logic [icdf_pkg::VAL_W-1:0]    r_data1;
        icdf_pkg::t_tag                r_tag2;
        logic [AW-1:0]                 r_addr2;
        logic [icdf_pkg::VAL_W-1:0]    r_data2;

        // stage one: quotient estimate, at most one below the true quotient
        assign w_prod = 47'(i_idx) * 47'(RECIP_W);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag1 <= '0;
            end else begin
                r_tag1 <= i_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            r_idx1  <= i_idx;
            r_q1    <= w_prod[46:32];
            r_data1 <= i_data;
        end

        // stage two: remainder below twice the depth, one subtract
        assign w_qd  = 30'(r_q1) * 30'(DEPTH_W);
        assign w_rem = 16'(30'(r_idx1) - w_qd);
        assign w_mod = (w_rem >= DEPTH_W) ? (w_rem - DEPTH_W) : w_rem;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag2 <= '0;
            end else begin
                r_tag2 <= r_tag1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_addr2 <= w_mod[AW-1:0];
            r_data2 <= r_data1;
        end

        assign o_tag  = r_tag2;
        assign o_addr = r_addr2;
        assign o_data = r_data2;
    end

`ifndef SYNTHESIS
    // every issued access lands inside the table
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tag.vld |-> (32'(o_addr) < 32'(TABLE_DEPTH)))
        else $error("table address beyond depth");
`endif

endmodule

// ----- tb/tb_inverse_cdf_table_sampler_unit.sv -----
// self-checking testbench of the inverse cdf table sampler: table loads, draws, top_value settings
module tb_inverse_cdf_table_sampler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VAL_W       = icdf_pkg::VAL_W;
    localparam int IDX_W       = icdf_pkg::IDX_W;
    localparam int APB_AW      = icdf_pkg::APB_AW;
    localparam int APB_DW      = icdf_pkg::APB_DW;
    localparam int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH;
    localparam icdf_pkg::t_cmd CMD_LOAD = icdf_pkg::CMD_LOAD;
    localparam icdf_pkg::t_cmd CMD_DRAW = icdf_pkg::CMD_DRAW;

    localparam logic [VAL_W-1:0]  ONE_FRAC       = 64'h8000_0000_0000_0000;
    localparam logic [VAL_W-1:0]  ALL_ONES       = '1;
    localparam logic [APB_AW-1:0] TOP_VALUE_ADDR = {icdf_pkg::REG_TOP_VALUE, 2'b00};
    localparam logic [IDX_W-1:0]  MAX_TOP        = 15'd32766;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 400;
    localparam int MAX_REPORTS     = 30;
    localparam int PHASE_ITEMS     = 90;
    localparam int BIG_PHASE_ITEMS = 20;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic               i_command;
    logic [IDX_W-1:0]   i_entry_index;
    logic [VAL_W-1:0]   i_entry_value;
    logic               o_done;
    logic [IDX_W-1:0]   o_sample_value;

    // own copy of the sampler state
    bit [VAL_W-1:0]  rng_a = 64'h7073_6575_646F_7261;
    bit [VAL_W-1:0]  rng_b = 64'h6E64_6F6D_7365_6564;
    bit [VAL_W-1:0]  cdf_copy [TABLE_DEPTH];
    bit              entry_loaded [TABLE_DEPTH];
    bit [IDX_W-1:0]  top_copy = '0;
    logic [IDX_W-1:0] pending_samples [$];

    int error_count    = 0;
    int loads_sent     = 0;
    int draws_sent     = 0;
    int samples_seen   = 0;
    int top_settings   = 0;
    int burst_left     = 0;

    inverse_cdf_table_sampler_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .o_done         (o_done),
        .o_sample_value (o_sample_value)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // run limit
    initial begin
        #100_000_000;
        $display("run limit reached, %0d samples pending", pending_samples.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // xorshift128+ step, top 63 bits of the sum, then bisection over the table copy
    function automatic logic [IDX_W-1:0] predict_sample();
        bit [VAL_W-1:0] s;
        bit [VAL_W-1:0] t;
        bit [VAL_W-1:0] u;
        int lo;
        int hi;
        int mid;
        s = rng_b;
        t = rng_a;
        u = (s + t) >> 1;
        rng_a = s;
        t = t ^ (t << 23);
        rng_b = t ^ s ^ (t >> 18) ^ (s >> 5);
        lo = 0;
        hi = int'(top_copy) + 1;
        while (lo + 1 < hi) begin
            mid = (lo + hi) >> 1;
            if (u < cdf_copy[mid % TABLE_DEPTH])
                hi = mid;
            else
                lo = mid;
        end
        return lo[IDX_W-1:0];
    endfunction

    // result checker: every strobe is matched against the oldest pending sample
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            samples_seen++;
            if (pending_samples.size() == 0)
                report_mismatch($sformatf("sample %0d with no draw outstanding", o_sample_value));
            else if (o_sample_value !== pending_samples[0])
                report_mismatch($sformatf("sample_value got %0d expected %0d",
                                          o_sample_value, pending_samples[0]));
            if (pending_samples.size() != 0)
                void'(pending_samples.pop_front());
        end
    end

    // sender pacing: bursts of random length, random gaps with junk on the fields
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                start         <= 1'b0;
                i_command     <= 1'($urandom);
                i_entry_index <= IDX_W'($urandom);
                i_entry_value <= {$urandom, $urandom};
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // one request: hold start until the block takes it, then predict
    task automatic send_request(icdf_pkg::t_cmd cmd, logic [IDX_W-1:0] idx,
                                logic [VAL_W-1:0] val);
        start         <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= idx;
        i_entry_value <= val;
        do @(posedge i_clk); while (busy);
        if (cmd == CMD_LOAD) begin
            cdf_copy[idx % TABLE_DEPTH] = val;
            entry_loaded[idx % TABLE_DEPTH] = 1'b1;
            loads_sent++;
        end else begin
            pending_samples.push_back(predict_sample());
            draws_sent++;
        end
        pace();
    endtask

    // one draw: first load every entry on its search path that was never written
    task automatic send_draw(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        bit [VAL_W-1:0] u;
        int lo;
        int hi;
        int mid;
        u = (rng_a + rng_b) >> 1;
        lo = 0;
        hi = int'(top_copy) + 1;
        while (lo + 1 < hi) begin
            mid = (lo + hi) >> 1;
            if (!entry_loaded[mid % TABLE_DEPTH])
                send_request(CMD_LOAD, IDX_W'(mid), (VAL_W'(mid) << 48) |
                             VAL_W'({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF));
            if (u < cdf_copy[mid % TABLE_DEPTH])
                hi = mid;
            else
                lo = mid;
        end
        send_request(CMD_DRAW, idx, val);
    endtask

    // stop sending and let every pending sample and table write finish
    task automatic settle();
        int waited = 0;
        start <= 1'b0;
        while (pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        while (pending_samples.size() != 0)
            report_mismatch($sformatf("expected sample %0d never arrived",
                                      pending_samples.pop_front()));
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write followed by a read back, upper data bits random
    task automatic set_top_value(logic [IDX_W-1:0] value);
        logic [APB_DW-1:0] word;
        settle();
        word = $urandom;
        word[IDX_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOP_VALUE_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        top_copy = value;
        top_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[IDX_W-1:0] !== value)
            report_mismatch($sformatf("top_value read back %0d expected %0d",
                                      prdata[IDX_W-1:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // monotone cdf over entries 1..top with random steps
    task automatic load_cdf_ramp(int top);
        logic [VAL_W-1:0] step;
        logic [VAL_W-1:0] val;
        step = ONE_FRAC / VAL_W'(top + 1);
        for (int i = 1; i <= top; i++) begin
            val = step * VAL_W'(i) - ({$urandom, $urandom} % (step >> 1));
            send_request(CMD_LOAD, IDX_W'(i), val);
        end
    endtask

    // top_value zero: draw advances the generator and returns 0
    task automatic test_top_zero();
        set_top_value('0);
        send_draw('0, '0);
        send_draw('1, ALL_ONES);
    endtask

    // extreme indexes and values: zero, exactly 1.0, above 1.0
    task automatic test_edge_entries();
        send_request(CMD_LOAD, '0, ALL_ONES);
        send_request(CMD_LOAD, '1, '0);
        send_request(CMD_LOAD, '1, ALL_ONES);
        set_top_value(15'd3);
        send_request(CMD_LOAD, 15'd1, '0);
        send_request(CMD_LOAD, 15'd2, ONE_FRAC);
        send_request(CMD_LOAD, 15'd3, ALL_ONES);
        send_draw('0, '0);
        send_draw('0, '0);
        // zero entry just before the search reads it
        send_request(CMD_LOAD, 15'd2, '0);
        send_draw('0, '0);
    endtask

    // non-monotone table: bisection still stays within 0..top_value
    task automatic test_nonmonotone();
        set_top_value(15'd5);
        send_request(CMD_LOAD, 15'd1, ONE_FRAC);
        send_request(CMD_LOAD, 15'd2, '0);
        send_request(CMD_LOAD, 15'd3, ALL_ONES);
        send_request(CMD_LOAD, 15'd4, '0);
        send_request(CMD_LOAD, 15'd5, {1'b0, $urandom, 31'($urandom)});
        send_draw('0, '0);
        send_draw('0, '0);
    endtask

    // top_value 32766, one below the register maximum: deepest search the bench runs
    task automatic test_full_range();
        set_top_value(MAX_TOP);
        repeat (3) send_draw('0, '0);
    endtask

    // random phases over several top_value settings, mostly draws
    task automatic test_random_phases();
        logic [IDX_W-1:0] top;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        int n_items;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: top = 15'd1;
                1: top = IDX_W'($urandom_range(2, 15));
                2: top = IDX_W'($urandom_range(16, 40));
                3: top = MAX_TOP;
                4: top = IDX_W'($urandom_range(41, MAX_TOP - 1));
                5: top = '0;
                6: top = IDX_W'($urandom_range(2, 40));
                default: top = IDX_W'($urandom_range(1, MAX_TOP));
            endcase
            set_top_value(top);
            if (top >= 1 && top <= 40)
                load_cdf_ramp(top);
            n_items = (top > 40) ? BIG_PHASE_ITEMS : PHASE_ITEMS;
            repeat (n_items) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_draw(IDX_W'($urandom), {$urandom, $urandom});
                end else begin
                    idx = (top != 0 && $urandom_range(0, 2) != 0)
                          ? IDX_W'($urandom_range(1, top)) : IDX_W'($urandom);
                    val = {$urandom, $urandom};
                    if ($urandom_range(0, 1) == 0)
                        val[VAL_W-1] = 1'b0;
                    send_request(CMD_LOAD, idx, val);
                end
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        start         <= 1'b0;
        i_command     <= CMD_LOAD;
        i_entry_index <= '0;
        i_entry_value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_top_zero();
        test_edge_entries();
        test_nonmonotone();
        test_full_range();
        test_random_phases();

        settle();
        repeat (20) @(posedge i_clk);
        $display("covered %0d table loads and %0d draws over %0d top_value settings",
                 loads_sent, draws_sent, top_settings);
        $display("%0d samples compared, %0d mismatches", samples_seen, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/icdf_pkg.sv
sv/icdf_ram.sv
sv/icdf_rng.sv
sv/icdf_amod.sv
sv/inverse_cdf_table_sampler_unit.sv
tb/tb_inverse_cdf_table_sampler_unit.sv
